@@ sv/pphm_pkg.sv @@
// Package for the pulse period history meter.
// Holds ring depth, derived widths, operation codes and controller/datapath structs.
// No dependencies.
package pphm_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);

    localparam int FUNC_W = 2;
    localparam int TIME_W = 32;
    localparam int DELTA_W = 16;
    localparam int TOTAL_W = 64;
    localparam int FILL_OUT_W = 5;
    localparam int SLOT_OUT_W = 4;

    localparam logic [FUNC_W-1:0] FUNC_PULSE  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SNAP   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    typedef struct packed {
        logic             pulse;
        logic             add_delta;
        logic             clear;
        logic             start;
        logic             load;
        logic             last;
        logic [IDX_W-1:0] slot;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ sv/pphm_if.sv @@
// Channel interfaces for the pulse period history meter: event input and snapshot output.
// Depends on pphm_pkg for field widths.
interface pphm_evt_if;
    logic                                valid;
    logic                                ready;
    logic [pphm_pkg::FUNC_W-1:0]         func;
    logic [pphm_pkg::TIME_W-1:0]         time_us;
    logic signed [pphm_pkg::DELTA_W-1:0] counter_delta;

    modport source (output valid, output func, output time_us, output counter_delta,
                    input ready);
    modport sink (input valid, input func, input time_us, input counter_delta,
                  output ready);
endinterface

interface pphm_snap_if;
    logic                              valid;
    logic                              ready;
    logic [pphm_pkg::TOTAL_W-1:0]      total_pulses;
    logic [pphm_pkg::TIME_W-1:0]       last_period_us;
    logic [pphm_pkg::TIME_W-1:0]       last_time_us;
    logic [pphm_pkg::FILL_OUT_W-1:0]   fill_count;
    logic [pphm_pkg::SLOT_OUT_W-1:0]   slot;
    logic [pphm_pkg::TIME_W-1:0]       slot_period_us;
    logic                              last;

    modport source (output valid, output total_pulses, output last_period_us,
                    output last_time_us, output fill_count, output slot,
                    output slot_period_us, output last, input ready);
    modport sink (input valid, input total_pulses, input last_period_us,
                  input last_time_us, input fill_count, input slot,
                  input slot_period_us, input last, output ready);
endinterface

@@ sv/pphm_ctrl.sv @@
// Controller of the pulse period history meter: decodes events, sequences snapshot beats.
// Depends on pphm_pkg and pphm_evt_if.
module pphm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    pphm_evt_if.sink             evt,
    input  pphm_pkg::status_t    status,
    output pphm_pkg::cmd_t       cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SNAP = 1'b1;

    logic                       state_reg;
    logic                       state_next;
    logic [pphm_pkg::IDX_W-1:0] cnt_reg;
    logic [pphm_pkg::IDX_W-1:0] cnt_next;
    logic                       accept;

    assign evt.ready = (state_reg == ST_IDLE);
    assign accept    = evt.valid && evt.ready;

    always_comb
    begin
        cmd.pulse     = accept && (evt.func == pphm_pkg::FUNC_PULSE);
        cmd.add_delta = accept && ((evt.func == pphm_pkg::FUNC_UPDATE) ||
                                   (evt.func == pphm_pkg::FUNC_SNAP));
        cmd.clear     = accept && (evt.func == pphm_pkg::FUNC_CLEAR);
        cmd.start     = accept && (evt.func == pphm_pkg::FUNC_SNAP);
        cmd.load      = (state_reg == ST_SNAP) && status.out_free;
        cmd.last      = (cnt_reg == pphm_pkg::IDX_W'(pphm_pkg::DEPTH - 1));
        cmd.slot      = cnt_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_SNAP;
                    cnt_next   = '0;
                end
            end
            ST_SNAP:
            begin
                if (cmd.load)
                begin
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (cnt_reg == '0))
        else $error("slot counter not zero while idle");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && cmd.last) |=> (state_reg == ST_IDLE))
        else $error("controller did not finish snapshot after final beat");

    a_start_enters_snap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == ST_SNAP) && (cnt_reg == '0))
        else $error("snapshot did not start at slot zero");

endmodule

@@ sv/pphm_dpath.sv @@
// Datapath of the pulse period history meter: totals, period ring and output register.
// Depends on pphm_pkg and pphm_snap_if; driven by pphm_ctrl commands.
module pphm_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pphm_pkg::cmd_t                      cmd,
    input  logic [pphm_pkg::TIME_W-1:0]         time_us,
    input  logic signed [pphm_pkg::DELTA_W-1:0] counter_delta,
    output pphm_pkg::status_t                   status,
    pphm_snap_if.source                         snap
);

    logic [pphm_pkg::TOTAL_W-1:0] total_reg;
    logic [pphm_pkg::TOTAL_W-1:0] total_next;
    logic [pphm_pkg::TIME_W-1:0]  period_reg;
    logic [pphm_pkg::TIME_W-1:0]  period_next;
    logic [pphm_pkg::TIME_W-1:0]  ref_reg;
    logic [pphm_pkg::TIME_W-1:0]  ref_next;
    logic [pphm_pkg::IDX_W-1:0]   wr_reg;
    logic [pphm_pkg::IDX_W-1:0]   wr_next;
    logic [pphm_pkg::IDX_W-1:0]   oldest_reg;
    logic [pphm_pkg::IDX_W-1:0]   oldest_next;
    logic [pphm_pkg::IDX_W-1:0]   rd_reg;
    logic [pphm_pkg::IDX_W-1:0]   rd_next;
    logic [pphm_pkg::FILL_W-1:0]  fill_reg;
    logic [pphm_pkg::FILL_W-1:0]  fill_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic [pphm_pkg::TIME_W-1:0]  ring [pphm_pkg::DEPTH];
    logic [pphm_pkg::TIME_W-1:0]  new_period;
    logic                         delta_pos;
    logic                         full;
    logic                         slot_in_fill;

    logic [pphm_pkg::TOTAL_W-1:0]    o_total_reg;
    logic [pphm_pkg::TIME_W-1:0]     o_period_reg;
    logic [pphm_pkg::TIME_W-1:0]     o_time_reg;
    logic [pphm_pkg::FILL_OUT_W-1:0] o_fill_reg;
    logic [pphm_pkg::SLOT_OUT_W-1:0] o_slot_reg;
    logic [pphm_pkg::TIME_W-1:0]     o_slot_period_reg;
    logic                            o_last_reg;

    function automatic logic [pphm_pkg::IDX_W-1:0] wrap_inc(
        input logic [pphm_pkg::IDX_W-1:0] p);
        wrap_inc = (p == pphm_pkg::IDX_W'(pphm_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign new_period   = time_us - ref_reg;
    assign delta_pos    = !counter_delta[pphm_pkg::DELTA_W-1] && (counter_delta != '0);
    assign full         = (fill_reg == pphm_pkg::FILL_W'(pphm_pkg::DEPTH));
    assign slot_in_fill = (pphm_pkg::FILL_W'(cmd.slot) < fill_reg);
    assign status.out_free = !out_valid_reg || snap.ready;

    always_comb
    begin
        total_next     = total_reg;
        period_next    = period_reg;
        ref_next       = ref_reg;
        wr_next        = wr_reg;
        oldest_next    = oldest_reg;
        rd_next        = rd_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;

        if (cmd.add_delta && delta_pos)
        begin
            total_next = total_reg +
                pphm_pkg::TOTAL_W'(counter_delta[pphm_pkg::DELTA_W-2:0]);
        end
        if (cmd.pulse)
        begin
            period_next = new_period;
            ref_next    = time_us;
            wr_next     = wrap_inc(wr_reg);
            if (full)
            begin
                oldest_next = wrap_inc(oldest_reg);
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (cmd.clear)
        begin
            total_next  = '0;
            period_next = '0;
            ref_next    = time_us;
            wr_next     = '0;
            oldest_next = '0;
            fill_next   = '0;
        end
        if (cmd.start)
        begin
            rd_next = oldest_reg;
        end
        if (cmd.load)
        begin
            rd_next        = wrap_inc(rd_reg);
            out_valid_next = 1'b1;
        end
        else if (snap.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            period_reg    <= '0;
            ref_reg       <= '0;
            wr_reg        <= '0;
            oldest_reg    <= '0;
            rd_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            period_reg    <= period_next;
            ref_reg       <= ref_next;
            wr_reg        <= wr_next;
            oldest_reg    <= oldest_next;
            rd_reg        <= rd_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ring and beat register; slots past the fill count are output as zero
    always_ff @(posedge clk)
    begin
        if (cmd.pulse)
        begin
            ring[wr_reg] <= new_period;
        end
        if (cmd.load)
        begin
            o_total_reg       <= total_reg;
            o_period_reg      <= period_reg;
            o_time_reg        <= ref_reg;
            o_fill_reg        <= pphm_pkg::FILL_OUT_W'(fill_reg);
            o_slot_reg        <= pphm_pkg::SLOT_OUT_W'(cmd.slot);
            o_slot_period_reg <= slot_in_fill ? ring[rd_reg] : '0;
            o_last_reg        <= cmd.last;
        end
    end

    assign snap.valid          = out_valid_reg;
    assign snap.total_pulses   = o_total_reg;
    assign snap.last_period_us = o_period_reg;
    assign snap.last_time_us   = o_time_reg;
    assign snap.fill_count     = o_fill_reg;
    assign snap.slot           = o_slot_reg;
    assign snap.slot_period_us = o_slot_period_reg;
    assign snap.last           = o_last_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= pphm_pkg::FILL_W'(pphm_pkg::DEPTH))
        else $error("fill count above ring depth");

    a_oldest_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (oldest_reg == '0) && (pphm_pkg::FILL_W'(wr_reg) == fill_reg))
        else $error("ring pointers inconsistent before ring fills");

    a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (fill_reg == '0) && (total_reg == '0) && (period_reg == '0))
        else $error("clear left state behind");

    a_load_no_event: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.pulse && !cmd.clear && !cmd.add_delta)
        else $error("state update during snapshot readout");

endmodule

@@ sv/pulse_period_history_meter.sv @@
// Top level of the pulse period history meter: controller plus datapath.
// Depends on pphm_pkg, pphm_if, pphm_ctrl and pphm_dpath.
// Pulse, counter update and clear: one event accepted per cycle outside snapshot readout.
// Snapshot: first beat loaded from the snapshot state into the output register, then one
// beat per ready cycle, one ring slot each; next event in the cycle after the final load.
// Reset clears all totals, pointers and the fill count; ring contents are masked by fill.
module pulse_period_history_meter (
    input  logic         clk,
    input  logic         rst_n,
    pphm_evt_if.sink     evt,
    pphm_snap_if.source  snap
);

    pphm_pkg::cmd_t    cmd;
    pphm_pkg::status_t status;

    pphm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .evt    (evt),
        .status (status),
        .cmd    (cmd)
    );

    pphm_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .time_us       (evt.time_us),
        .counter_delta (evt.counter_delta),
        .status        (status),
        .snap          (snap)
    );

endmodule
